// File: rtl/sssd_pkg.sv
// shared types, constants and the character map of the seven-segment scan driver
package sssd_pkg;

  localparam int DIGITS  = 3;
  localparam int CHR_W   = 8;
  localparam int POS_W   = 3;
  localparam int CUR_W   = 4;
  localparam int SEG_W   = 8;
  localparam int BLINK_W = 16;
  localparam int IDX_W   = (DIGITS > 1) ? $clog2(DIGITS) : 1;

  localparam logic [CHR_W-1:0] CHR_DASH  = 8'h2D;
  localparam logic [CHR_W-1:0] CHR_BLANK = 8'h00;
  localparam logic [SEG_W-1:0] SEG_DP    = 8'h01;

  typedef enum logic [1:0] {
    REQ_SCAN  = 2'd0,
    REQ_PUT   = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_MOVE  = 2'd3
  } req_t;

  typedef struct packed {
    req_t             req_type;
    logic [CHR_W-1:0] char_code;
    logic [POS_W-1:0] target_pos;
  } item_t;

  typedef struct packed {
    logic             scan;
    logic [SEG_W-1:0] segment_bits;
    logic [POS_W-1:0] digit_index;
    logic             digit_lit;
    logic [CUR_W-1:0] cursor_pos;
  } result_t;

  function automatic logic [SEG_W-1:0] seg_pattern(input logic [CHR_W-1:0] c);
    logic [SEG_W-1:0] s;
    unique case (c)
      8'h30:   s = 8'hEE;
      8'h31:   s = 8'h48;
      8'h32:   s = 8'hF2;
      8'h33:   s = 8'hB6;
      8'h34:   s = 8'h3C;
      8'h35:   s = 8'h9E;
      8'h36:   s = 8'hDE;
      8'h37:   s = 8'h26;
      8'h38:   s = 8'hFE;
      8'h39:   s = 8'hBE;
      8'h2D:   s = 8'h10;
      8'h41:   s = 8'h7F;
      8'h43:   s = 8'hCA;
      8'h45:   s = 8'hDA;
      8'h4C:   s = 8'hC8;
      8'h48:   s = 8'h7C;
      8'h2E:   s = 8'h01;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

endpackage

// File: rtl/sssd_core.sv
// display state (character buffer, cursor, scan position, blink counter) and request datapath
module sssd_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [sssd_pkg::BLINK_W-1:0]  cfg_wdata,
  input  logic                          step,
  input  sssd_pkg::item_t               item,
  output sssd_pkg::result_t             result
);
  import sssd_pkg::*;

  logic [BLINK_W-1:0] blink_period;
  logic [CHR_W-1:0]   char_buffer [DIGITS];
  logic [POS_W-1:0]   scan_position;
  logic [CUR_W-1:0]   write_cursor;
  logic [BLINK_W-1:0] blink_count;

  logic [POS_W-1:0]   scan_position_next;
  logic [CUR_W-1:0]   write_cursor_next;
  logic [BLINK_W-1:0] blink_count_next;
  logic [POS_W:0]     scan_sum;
  logic [BLINK_W:0]   blink_sum;
  logic               put_ok;

  assign put_ok = (write_cursor < CUR_W'(DIGITS));

  always_comb begin
    scan_sum           = {1'b0, scan_position} + (POS_W+1)'(1);
    blink_sum          = {1'b0, blink_count} + (BLINK_W+1)'(1);
    scan_position_next = scan_position;
    write_cursor_next  = write_cursor;
    blink_count_next   = blink_count;
    result             = '0;
    unique case (item.req_type)
      REQ_SCAN: begin
        if (scan_sum >= (POS_W+1)'(DIGITS)) begin
          scan_position_next = '0;
        end else begin
          scan_position_next = scan_sum[POS_W-1:0];
        end
        // a count that passes the period restarts from zero
        if (blink_sum > {1'b0, blink_period}) begin
          blink_count_next = '0;
        end else begin
          blink_count_next = blink_sum[BLINK_W-1:0];
        end
        result.scan         = 1'b1;
        result.segment_bits = seg_pattern(char_buffer[scan_position_next[IDX_W-1:0]]);
        if (scan_position_next == POS_W'(1)) begin
          result.segment_bits = result.segment_bits | SEG_DP;
        end
        result.digit_lit   = (blink_count_next >= (blink_period >> 1));
        result.digit_index = scan_position_next;
      end
      REQ_PUT: begin
        if (put_ok) begin
          write_cursor_next = write_cursor + CUR_W'(1);
        end
      end
      REQ_CLEAR: begin
        write_cursor_next = '0;
      end
      REQ_MOVE: begin
        if ({1'b0, item.target_pos} < CUR_W'(DIGITS)) begin
          write_cursor_next = {1'b0, item.target_pos};
        end
      end
      default: begin
      end
    endcase
    result.cursor_pos = write_cursor_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      blink_period <= '0;
    end else if (cfg_we) begin
      blink_period <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_position <= '0;
      write_cursor  <= '0;
      blink_count   <= '0;
      for (int i = 0; i < DIGITS; i++) begin
        char_buffer[i] <= CHR_DASH;
      end
    end else if (step) begin
      scan_position <= scan_position_next;
      write_cursor  <= write_cursor_next;
      blink_count   <= blink_count_next;
      for (int i = 0; i < DIGITS; i++) begin
        if (item.req_type == REQ_CLEAR) begin
          char_buffer[i] <= CHR_BLANK;
        end else if (item.req_type == REQ_PUT && put_ok &&
                     write_cursor[IDX_W-1:0] == IDX_W'(i)) begin
          char_buffer[i] <= item.char_code;
        end
      end
    end
  end

endmodule

// File: rtl/seven_segment_scan_driver.sv
// top level of the seven-segment scan driver: input register, core and result register
//
// Multiplexed seven-segment display driver. Each transaction on the s_ side is a
// request (scan tick, put character, clear, move cursor) and gives exactly one
// result transaction on the m_ side. One request is taken every clock cycle unless the
// pipeline stalls; a result passes through the input register and then the result
// register. The whole pipeline stalls only while a result waits on m_tready with the
// next request already registered. The blink period is written through cfg_we / cfg_wdata;
// the user must write it only while no request is in flight; the block does not enforce this.
module seven_segment_scan_driver (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // char_code[7:0], target_pos[10:8], zero [15:11]
  input  logic [1:0]  s_tuser,   // req_type[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // segment_bits[7:0], digit_index[10:8], digit_lit[11],
                                 // cursor_pos[15:12]
);
  import sssd_pkg::*;

  logic    in_valid;
  item_t   in_item;
  logic    out_valid;
  result_t out_result;
  result_t core_result;
  logic    advance;
  logic    step;

  assign advance  = !out_valid || m_tready;
  assign step     = in_valid && advance;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item.req_type   <= req_t'(s_tuser);
      in_item.char_code  <= s_tdata[7:0];
      in_item.target_pos <= s_tdata[10:8];
    end
  end

  sssd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .step      (step),
    .item      (in_item),
    .result    (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_result <= core_result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_result.cursor_pos, out_result.digit_lit,
                     out_result.digit_index, out_result.segment_bits};

  // an empty result register always leaves room for a new request
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> s_tready)
    else $error("request stalled with empty result register");

  a_non_scan_blank: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_result.scan |->
      out_result.segment_bits == '0 && out_result.digit_index == '0 && !out_result.digit_lit)
    else $error("non-scan result carries display fields");

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_result.cursor_pos <= CUR_W'(DIGITS))
    else $error("cursor beyond buffer");

  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_result.digit_index < POS_W'(DIGITS))
    else $error("scanned digit beyond buffer");

  a_decimal_point: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_result.scan && out_result.digit_index == POS_W'(1) |->
      out_result.segment_bits[0])
    else $error("decimal point missing on digit one");

endmodule
